// ===== src/dpsm_pkg.sv =====
// Shared types, constants and status encoding for the drive power state machine.
package dpsm_pkg;

   typedef enum logic [2:0] {
      ST_NOT_READY = 3'd0,
      ST_DISABLED  = 3'd1,
      ST_READY     = 3'd2,
      ST_ON        = 3'd3,
      ST_ENABLED   = 3'd4,
      ST_QSTOP     = 3'd5,
      ST_REACTION  = 3'd6,
      ST_FAULT     = 3'd7
   } drive_state_type;

   localparam logic [15:0]       STATUS_TARGET_REACHED = 16'h0400;
   localparam logic [15:0]       STATUS_HOMING_DONE    = 16'h1000;
   localparam logic signed [7:0] MODE_HOMING           = 8'sd6;
   localparam int                CW_FAULT_RESET_BIT    = 7;

   typedef struct packed {
      logic [15:0]       control_word;
      logic signed [7:0] mode_active;
      logic signed [7:0] mode_wanted;
      logic              homing_done;
      logic              fault_trigger;
      logic [15:0]       fault_code;
   } req_item_type;

   typedef struct packed {
      drive_state_type state;
      logic [15:0]     error_value;
      logic            reset_bit_last;
   } drive_ctx_type;

   function automatic logic [15:0] base_status(input drive_state_type s);
      logic [15:0] sw;
      case (s)
         ST_NOT_READY: sw = 16'h0000;
         ST_DISABLED:  sw = 16'h0040;
         ST_READY:     sw = 16'h0021;
         ST_ON:        sw = 16'h0023;
         ST_ENABLED:   sw = 16'h0027;
         ST_QSTOP:     sw = 16'h0007;
         ST_REACTION:  sw = 16'h000F;
         ST_FAULT:     sw = 16'h0008;
         default:      sw = 16'h0000;
      endcase
      return sw;
   endfunction

endpackage

// ===== src/dpsm_step.sv =====
// Next-state, error register and status word logic for one control word.
module dpsm_step
   import dpsm_pkg::*;
(
   input  req_item_type  item,
   input  drive_ctx_type ctx,
   output drive_ctx_type ctx_next,
   output logic [15:0]   status_word
);

   logic [15:0]     cw;
   logic            reset_bit;
   drive_state_type cw_state;

   assign cw        = item.control_word;
   assign reset_bit = cw[CW_FAULT_RESET_BIT];

   always_comb begin
      cw_state = ctx.state;
      case (ctx.state)
         ST_NOT_READY: cw_state = ST_DISABLED;
         ST_DISABLED: begin
            if (cw[2:0] == 3'b110) cw_state = ST_READY;
         end
         ST_READY: begin
            if (cw[2:0] == 3'b111) cw_state = ST_ON;
            else if (!cw[1]) cw_state = ST_DISABLED;
         end
         ST_ON: begin
            if (cw[3:0] == 4'b1111) cw_state = ST_ENABLED;
            else if (cw[2:0] == 3'b110) cw_state = ST_READY;
            else if (!cw[1]) cw_state = ST_DISABLED;
         end
         ST_ENABLED: begin
            if (!cw[2]) cw_state = ST_QSTOP;
            else if (!cw[3]) cw_state = ST_ON;
            else if (cw[2:0] == 3'b110) cw_state = ST_READY;
            else if (!cw[1]) cw_state = ST_DISABLED;
         end
         ST_QSTOP: begin
            if (cw[3:0] == 4'b1111) cw_state = ST_ENABLED;
            else if (!cw[1]) cw_state = ST_DISABLED;
         end
         ST_REACTION: cw_state = ST_FAULT;
         ST_FAULT: begin
            if (reset_bit && !ctx.reset_bit_last) cw_state = ST_DISABLED;
         end
         default: cw_state = ctx.state;
      endcase
   end

   always_comb begin
      ctx_next = ctx;
      if (item.fault_trigger && ctx.state != ST_REACTION && ctx.state != ST_FAULT) begin
         ctx_next.state       = ST_REACTION;
         ctx_next.error_value = item.fault_code;
      end else begin
         ctx_next.state = cw_state;
         if (ctx.state == ST_FAULT) begin
            ctx_next.reset_bit_last = reset_bit;
            if (reset_bit && !ctx.reset_bit_last) ctx_next.error_value = 16'h0000;
         end
      end
   end

   always_comb begin
      status_word = base_status(ctx_next.state);
      if (item.mode_active == item.mode_wanted) status_word = status_word | STATUS_TARGET_REACHED;
      if (item.homing_done && item.mode_active == MODE_HOMING) begin
         status_word = status_word | STATUS_HOMING_DONE;
      end
   end

endmodule

// ===== src/drive_power_state_machine.sv =====
// Top level of the drive power state machine: input register, step logic, result register.
//
// Usage: each transfer on the req_ channel carries one control word together with the
// active and wanted modes, the homing flag and a fault request with its error code.
// Every accepted transfer yields exactly one transfer on the rsp_ channel with the
// status word, the new state code and the stored error value.
// An accepted item moves from the input register through the step logic into the result
// register; throughput is one item per cycle unless the result is stalled. The state, error
// and edge registers are loaded together with the result register and drive its outputs.
// When the receiver asserts rsp_stall, the result register holds its contents and
// the input register can still take one more item; req_stall rises only when both
// registers are full and the result is stalled.
// A synchronous reset empties both registers and puts the drive in the not ready to
// switch on state with a cleared error register and fault-reset edge register.
module drive_power_state_machine
   import dpsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [15:0]       req_control_word,
   input  logic signed [7:0] req_mode_active,
   input  logic signed [7:0] req_mode_wanted,
   input  logic              req_homing_done,
   input  logic              req_fault_trigger,
   input  logic [15:0]       req_fault_code,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [15:0]       rsp_status_word,
   output logic [2:0]        rsp_state_code,
   output logic [15:0]       rsp_error_value
);

   logic          in_valid_ff;
   req_item_type  in_item_ff;
   logic          out_valid_ff;
   logic [15:0]   out_status_ff;
   drive_ctx_type ctx_ff;
   drive_ctx_type ctx_in;
   logic [15:0]   status_in;
   logic          advance;
   logic          req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   dpsm_step u_step (
      .item        (in_item_ff),
      .ctx         (ctx_ff),
      .ctx_next    (ctx_in),
      .status_word (status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctx_ff       <= '{state: ST_NOT_READY, error_value: 16'h0000, reset_bit_last: 1'b0};
      end else begin
         if (req_take) in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;
         if (advance) begin
            out_valid_ff <= 1'b1;
            ctx_ff       <= ctx_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.control_word  <= req_control_word;
         in_item_ff.mode_active   <= req_mode_active;
         in_item_ff.mode_wanted   <= req_mode_wanted;
         in_item_ff.homing_done   <= req_homing_done;
         in_item_ff.fault_trigger <= req_fault_trigger;
         in_item_ff.fault_code    <= req_fault_code;
      end
      if (advance) out_status_ff <= status_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status_word = out_status_ff;
   assign rsp_state_code  = ctx_ff.state;
   assign rsp_error_value = ctx_ff.error_value;

endmodule

// ===== src/dpsm_checker.sv =====
// Port-level assertions for the drive power state machine and their bind.
module dpsm_checker
   import dpsm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [15:0]       rsp_status_word,
   input logic [2:0]        rsp_state_code,
   input logic [15:0]       rsp_error_value
);

   // A stalled result stays in place unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status_word)
         && $stable(rsp_state_code) && $stable(rsp_error_value))
      else $error("stalled result changed");

   // The low status bits always match the reported state.
   a_status_base: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status_word & 16'h00FF) == base_status(drive_state_type'(rsp_state_code)))
      else $error("status word does not match state");

   // The drive always leaves not ready to switch on on its first item.
   a_never_not_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_state_code != ST_NOT_READY)
      else $error("result reports not ready to switch on");

   // An error code is only held while in a fault state.
   a_error_only_faulted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_state_code != ST_REACTION && rsp_state_code != ST_FAULT
         |-> rsp_error_value == 16'h0000)
      else $error("error value held outside fault states");

endmodule

bind drive_power_state_machine dpsm_checker u_dpsm_checker (.*);

// ===== test/tb_drive_power_state_machine.sv =====
// Self-checking testbench for the drive power state machine with a predicting scoreboard.
module tb_drive_power_state_machine;
   import dpsm_pkg::*;

   typedef struct {
      logic [15:0]     status_word;
      drive_state_type state_code;
      logic [15:0]     error_value;
   } drive_status_type;

   localparam logic [15:0] STATUS_OF_STATE [8] = '{
      16'h0000, 16'h0040, 16'h0021, 16'h0023, 16'h0027, 16'h0007, 16'h000F, 16'h0008
   };

   localparam logic [15:0] CW_COMMANDS [10] = '{
      16'h0006, 16'h0007, 16'h000F, 16'h000B, 16'h0000,
      16'h0002, 16'h0080, 16'h000D, 16'h000E, 16'h0001
   };

   class drive_scoreboard;
      drive_state_type  drive_state;
      logic [15:0]      stored_error;
      logic             fault_reset_last;
      drive_status_type expected_q[$];
      int unsigned      mismatches;
      int unsigned      requests;
      int unsigned      results;
      int unsigned      fault_entries;
      int unsigned      fault_clears;
      logic [7:0]       states_seen;

      function new();
         drive_state      = ST_NOT_READY;
         stored_error     = 16'h0000;
         fault_reset_last = 1'b0;
         mismatches       = 0;
         requests         = 0;
         results          = 0;
         fault_entries    = 0;
         fault_clears     = 0;
         states_seen      = 8'h00;
      endfunction

      function void note_request(input req_item_type it);
         logic [15:0]      cw;
         drive_status_type exp_status;
         cw = it.control_word;
         requests++;
         if (it.fault_trigger && drive_state != ST_REACTION && drive_state != ST_FAULT) begin
            drive_state  = ST_REACTION;
            stored_error = it.fault_code;
            fault_entries++;
         end else begin
            case (drive_state)
               ST_NOT_READY: drive_state = ST_DISABLED;
               ST_DISABLED: begin
                  if (cw[2:0] == 3'b110) drive_state = ST_READY;
               end
               ST_READY: begin
                  if (cw[2:0] == 3'b111) drive_state = ST_ON;
                  else if (!cw[1]) drive_state = ST_DISABLED;
               end
               ST_ON: begin
                  if (cw[3:0] == 4'hF) drive_state = ST_ENABLED;
                  else if (cw[2:0] == 3'b110) drive_state = ST_READY;
                  else if (!cw[1]) drive_state = ST_DISABLED;
               end
               ST_ENABLED: begin
                  if (!cw[2]) drive_state = ST_QSTOP;
                  else if (!cw[3]) drive_state = ST_ON;
                  else if (cw[2:0] == 3'b110) drive_state = ST_READY;
                  else if (!cw[1]) drive_state = ST_DISABLED;
               end
               ST_QSTOP: begin
                  if (cw[3:0] == 4'hF) drive_state = ST_ENABLED;
                  else if (!cw[1]) drive_state = ST_DISABLED;
               end
               ST_REACTION: drive_state = ST_FAULT;
               default: begin
                  if (cw[CW_FAULT_RESET_BIT] && !fault_reset_last) begin
                     drive_state  = ST_DISABLED;
                     stored_error = 16'h0000;
                     fault_clears++;
                  end
                  fault_reset_last = cw[CW_FAULT_RESET_BIT];
               end
            endcase
         end
         states_seen[drive_state] = 1'b1;
         exp_status.status_word = STATUS_OF_STATE[drive_state];
         if (it.mode_active == it.mode_wanted)
            exp_status.status_word |= STATUS_TARGET_REACHED;
         if (it.homing_done && it.mode_active == MODE_HOMING)
            exp_status.status_word |= STATUS_HOMING_DONE;
         exp_status.state_code  = drive_state;
         exp_status.error_value = stored_error;
         expected_q = {expected_q, exp_status};
      endfunction

      task report(input string msg);
         $display("%0t ERROR %s", $time, msg);
         mismatches++;
      endtask

      task check_result(input logic [15:0] status_word, input logic [2:0] state_code,
                        input logic [15:0] error_value);
         drive_status_type exp_status;
         results++;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result transfer: status %h state %0d error %h",
                             status_word, state_code, error_value));
         end else begin
            exp_status = expected_q.pop_front();
            if (status_word !== exp_status.status_word)
               report($sformatf("status word %h, expected %h",
                                status_word, exp_status.status_word));
            if (state_code !== exp_status.state_code)
               report($sformatf("state code %0d, expected %0d",
                                state_code, exp_status.state_code));
            if (error_value !== exp_status.error_value)
               report($sformatf("error value %h, expected %h",
                                error_value, exp_status.error_value));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [15:0]       req_control_word;
   logic signed [7:0] req_mode_active;
   logic signed [7:0] req_mode_wanted;
   logic              req_homing_done;
   logic              req_fault_trigger;
   logic [15:0]       req_fault_code;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [15:0]       rsp_status_word;
   logic [2:0]        rsp_state_code;
   logic [15:0]       rsp_error_value;

   drive_scoreboard sb;

   drive_power_state_machine dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_control_word  (req_control_word),
      .req_mode_active   (req_mode_active),
      .req_mode_wanted   (req_mode_wanted),
      .req_homing_done   (req_homing_done),
      .req_fault_trigger (req_fault_trigger),
      .req_fault_code    (req_fault_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status_word   (rsp_status_word),
      .rsp_state_code    (rsp_state_code),
      .rsp_error_value   (rsp_error_value)
   );

   always #6 clock = ~clock;

   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   task automatic send_item(input req_item_type it);
      req_control_word  <= it.control_word;
      req_mode_active   <= it.mode_active;
      req_mode_wanted   <= it.mode_wanted;
      req_homing_done   <= it.homing_done;
      req_fault_trigger <= it.fault_trigger;
      req_fault_code    <= it.fault_code;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_request(input int unsigned cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_command(input logic [15:0] cw, input logic signed [7:0] mode_a,
                               input logic signed [7:0] mode_w, input logic homed,
                               input logic fault, input logic [15:0] code);
      req_item_type it;
      it.control_word  = cw;
      it.mode_active   = mode_a;
      it.mode_wanted   = mode_w;
      it.homing_done   = homed;
      it.fault_trigger = fault;
      it.fault_code    = code;
      send_item(it);
      idle_request(gap_length());
   endtask

   always @(posedge clock) begin
      req_item_type seen;
      if (!reset && req_valid && !req_stall) begin
         seen.control_word  = req_control_word;
         seen.mode_active   = req_mode_active;
         seen.mode_wanted   = req_mode_wanted;
         seen.homing_done   = req_homing_done;
         seen.fault_trigger = req_fault_trigger;
         seen.fault_code    = req_fault_code;
         sb.note_request(seen);
      end
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_status_word, rsp_state_code, rsp_error_value);
   end

   initial begin
      rsp_stall = 1'b0;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(40, 150)) @(posedge clock);
         repeat (1 + gap_length()) @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (1 + gap_length()) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      #3_000_000;
      $display("drive_power_state_machine: mismatch");
      $finish;
   end

   initial begin
      req_item_type it;
      int unsigned  pick;
      int unsigned  back_to_back;
      sb                = new();
      clock             = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_control_word  = 16'h0000;
      req_mode_active   = 8'sd0;
      req_mode_wanted   = 8'sd0;
      req_homing_done   = 1'b0;
      req_fault_trigger = 1'b0;
      req_fault_code    = 16'h0000;
      back_to_back      = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Walk the power states, then enter and clear faults including a held reset bit.
      send_command(16'hFFFF, -8'sd128, -8'sd128, 1'b1, 1'b0, 16'h0000);
      send_command(16'h0006, 8'sd127, -8'sd128, 1'b0, 1'b0, 16'hFFFF);
      send_command(16'h0007, MODE_HOMING, MODE_HOMING, 1'b1, 1'b0, 16'h0000);
      send_command(16'h000F, MODE_HOMING, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0007, MODE_HOMING, 8'sd1, 1'b1, 1'b0, 16'h0000);
      send_command(16'h000F, 8'sd1, 8'sd1, 1'b0, 1'b0, 16'h0000);
      send_command(16'h000B, -8'sd1, 8'sd127, 1'b0, 1'b0, 16'h0000);
      send_command(16'h000F, 8'sd3, 8'sd3, 1'b0, 1'b0, 16'h0000);
      send_command(16'h000E, 8'sd3, 8'sd4, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0000, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0006, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0007, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0006, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0007, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0001, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0006, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0007, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h000F, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h000D, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h000F, 8'sd0, 8'sd0, 1'b0, 1'b1, 16'hFFFF);
      send_command(16'h0080, 8'sd0, 8'sd0, 1'b0, 1'b1, 16'h1234);
      send_command(16'hFF7F, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0080, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0006, 8'sd0, 8'sd0, 1'b0, 1'b1, 16'h8001);
      send_command(16'h0080, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0080, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0000, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);
      send_command(16'h0080, 8'sd0, 8'sd0, 1'b0, 1'b0, 16'h0000);

      // Mostly protocol commands, some with random upper bits, and some fully random words.
      repeat (500) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            it.control_word = CW_COMMANDS[$urandom_range(0, 9)];
            if ($urandom_range(0, 2) == 0)
               it.control_word[15:4] = 12'($urandom());
         end else begin
            it.control_word = 16'($urandom());
         end
         it.mode_active = 8'($urandom());
         it.mode_wanted = 8'($urandom());
         pick = $urandom_range(0, 9);
         if (pick < 4) it.mode_wanted = it.mode_active;
         else if (pick < 6) it.mode_active = MODE_HOMING;
         if (pick == 5) it.mode_wanted = MODE_HOMING;
         it.homing_done   = 1'($urandom());
         it.fault_trigger = ($urandom_range(0, 99) < 6);
         it.fault_code    = 16'($urandom());
         send_item(it);
         if (back_to_back > 0) begin
            back_to_back--;
         end else begin
            if ($urandom_range(0, 19) == 0) back_to_back = $urandom_range(10, 30);
            idle_request(gap_length());
         end
      end
      req_valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      $display("Run covered %0d request transfers and %0d result transfers, states seen %b.",
               sb.requests, sb.results, sb.states_seen);
      $display("Faults entered %0d times and cleared %0d times by a reset edge.",
               sb.fault_entries, sb.fault_clears);
      if (sb.mismatches == 0)
         $display("drive_power_state_machine: match");
      else
         $display("drive_power_state_machine: mismatch");
      $finish;
   end

endmodule
